@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the median filter RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/m5v_pkg.sv @@
// Shared constants and types for the median-of-five filter with velocity.
// No dependencies; used by every module of the block.
`default_nettype none

package m5v_pkg;

    // Window geometry and sample width.
    localparam int WINDOW_SIZE = 5;
    localparam int SAMPLE_BITS = 12;
    localparam int SLOT_BITS   = $clog2(WINDOW_SIZE);
    localparam int RANK_BITS   = $clog2(WINDOW_SIZE);
    localparam int MEDIAN_RANK = WINDOW_SIZE / 2;

    typedef logic [SAMPLE_BITS-1:0]        sample_t;
    typedef logic signed [SAMPLE_BITS:0]   velocity_t;
    typedef logic [SLOT_BITS-1:0]          slot_t;
    typedef logic [RANK_BITS-1:0]          rank_t;
    typedef sample_t [WINDOW_SIZE-1:0]     window_t;

endpackage

`default_nettype wire

@@ hw/rtl/m5v_window.sv @@
// Ring of recent samples with its write slot and the stage valid flag.
// Depends on m5v_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module m5v_window (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire m5v_pkg::sample_t sample,
    input  wire logic             advance,
    output m5v_pkg::window_t      window,
    output logic                  valid
);

    m5v_pkg::window_t window_reg;
    m5v_pkg::window_t window_next;
    m5v_pkg::slot_t   slot_reg;
    m5v_pkg::slot_t   slot_next;
    logic             valid_reg;
    logic             valid_next;

    // Write the new sample over the oldest entry and step the slot with wrap.
    always_comb
    begin
        window_next = window_reg;
        slot_next   = slot_reg;
        if (load)
        begin
            window_next[slot_reg] = sample;
            if (slot_reg == m5v_pkg::SLOT_BITS'(m5v_pkg::WINDOW_SIZE - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + m5v_pkg::SLOT_BITS'(1);
            end
        end
    end

    // The stage holds a request from load until the output stage takes it.
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            slot_reg   <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            slot_reg   <= slot_next;
            valid_reg  <= valid_next;
        end
    end

    assign window = window_reg;
    assign valid  = valid_reg;

    `ASSERT_IMPL(a_slot_in_range, clk, rst_n, 1'b1,
        slot_reg < m5v_pkg::SLOT_BITS'(m5v_pkg::WINDOW_SIZE))
    `ASSERT_NEXT(a_load_sets_valid, clk, rst_n, load, valid_reg)
    `ASSERT_NEXT(a_load_moves_slot, clk, rst_n, load, slot_reg != $past(slot_reg))
    `ASSERT_NEXT(a_idle_keeps_slot, clk, rst_n, !load, slot_reg == $past(slot_reg))

endmodule

`default_nettype wire

@@ hw/rtl/m5v_median.sv @@
// Rank-select median of the sample window.
// Depends on m5v_pkg.
`default_nettype none

module m5v_median (
    input  wire m5v_pkg::window_t window,
    output m5v_pkg::sample_t      median
);

    // Each entry counts the entries ordered before it (ties broken by position);
    // the entry whose count equals the middle rank is the median.
    always_comb
    begin
        m5v_pkg::rank_t   rank;
        m5v_pkg::sample_t result;
        result = '0;
        for (int i = 0; i < m5v_pkg::WINDOW_SIZE; i++)
        begin
            rank = '0;
            for (int j = 0; j < m5v_pkg::WINDOW_SIZE; j++)
            begin
                if (j != i)
                begin
                    if ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i)))
                    begin
                        rank = rank + m5v_pkg::RANK_BITS'(1);
                    end
                end
            end
            if (rank == m5v_pkg::RANK_BITS'(m5v_pkg::MEDIAN_RANK))
            begin
                result = result | window[i];
            end
        end
        median = result;
    end

endmodule

`default_nettype wire

@@ hw/rtl/m5v_velocity.sv @@
// Signed difference of two filtered positions and its magnitude.
// Depends on m5v_pkg.
`default_nettype none

module m5v_velocity (
    input  wire m5v_pkg::sample_t current,
    input  wire m5v_pkg::sample_t previous,
    output m5v_pkg::velocity_t    velocity,
    output m5v_pkg::sample_t      speed
);

    m5v_pkg::velocity_t diff;
    m5v_pkg::velocity_t diff_neg;

    // Zero-extend both positions so the difference always fits one bit wider.
    always_comb
    begin
        diff     = $signed({1'b0, current}) - $signed({1'b0, previous});
        diff_neg = -diff;
        velocity = diff;
        if (diff[m5v_pkg::SAMPLE_BITS])
        begin
            speed = diff_neg[m5v_pkg::SAMPLE_BITS-1:0];
        end
        else
        begin
            speed = diff[m5v_pkg::SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/median5_filter_with_velocity.sv @@
// Median-of-five position filter with velocity and speed outputs.
//
// Input channel: in_valid / in_stall carry one 12-bit adc_sample per request.
// Output channel: out_valid / out_stall carry one result per input request:
// filtered_position (median of the last five samples), velocity (signed
// difference to the previous filtered position) and speed (its magnitude).
// Timing: a sample accepted at one clock edge is written into the window at
// that edge, and its result is loaded into the output registers when the
// window stage advances, which waits while the output is held by out_stall.
// Throughput: one request per cycle, sustained while out_stall does not hold
// the output, set by the single window register stage ahead of the outputs.
// Stalls: while the output holds a result under out_stall, the window stage
// can still take one more request; once both are full, in_stall rises until
// the output drains.
// Reset (rst_n low, asynchronous) clears the window to zeros, the write slot,
// the previous filtered position and both valid flags, so the first results
// after reset take zeros from the unfilled window entries.
// Depends on m5v_pkg, m5v_window, m5v_median, m5v_velocity, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module median5_filter_with_velocity (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire m5v_pkg::sample_t   adc_sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output m5v_pkg::sample_t        filtered_position,
    output m5v_pkg::velocity_t      velocity,
    output m5v_pkg::sample_t        speed
);

    logic                 stage_valid;
    logic                 stage_advance;
    m5v_pkg::window_t     window;
    m5v_pkg::sample_t     median;
    m5v_pkg::velocity_t   velocity_calc;
    m5v_pkg::sample_t     speed_calc;
    logic                 load;
    logic                 out_busy;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    m5v_pkg::sample_t     position_reg;
    m5v_pkg::velocity_t   velocity_reg;
    m5v_pkg::sample_t     speed_reg;
    m5v_pkg::sample_t     prev_reg;
    m5v_pkg::sample_t     prev_next;

    // Flow control: the window stage moves on when the output register is free.
    assign out_busy      = out_valid_reg && out_stall;
    assign stage_advance = stage_valid && !out_busy;
    assign in_stall      = stage_valid && out_busy;
    assign load          = in_valid && !in_stall;

    m5v_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .sample  (adc_sample),
        .advance (stage_advance),
        .window  (window),
        .valid   (stage_valid)
    );

    m5v_median u_median (
        .window (window),
        .median (median)
    );

    m5v_velocity u_velocity (
        .current  (median),
        .previous (prev_reg),
        .velocity (velocity_calc),
        .speed    (speed_calc)
    );

    // Output valid and previous-position bookkeeping.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        prev_next      = prev_reg;
        if (stage_advance)
        begin
            out_valid_next = 1'b1;
            prev_next      = median;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
        end
    end

    // Result payload registers load only when a request moves in.
    always_ff @(posedge clk)
    begin
        if (stage_advance)
        begin
            position_reg <= median;
            velocity_reg <= velocity_calc;
            speed_reg    <= speed_calc;
        end
    end

    assign out_valid         = out_valid_reg;
    assign filtered_position = position_reg;
    assign velocity          = velocity_reg;
    assign speed             = speed_reg;

    `ASSERT_IMPL(a_in_stall_cause, clk, rst_n, in_stall, out_valid_reg && out_stall)
    `ASSERT_NEXT(a_advance_fills_out, clk, rst_n, stage_advance,
        out_valid_reg && (prev_reg == position_reg))
    `ASSERT_IMPL(a_speed_matches, clk, rst_n, out_valid_reg,
        (velocity_reg[m5v_pkg::SAMPLE_BITS] ?
            (m5v_pkg::SAMPLE_BITS'(-velocity_reg) == speed_reg) :
            (velocity_reg[m5v_pkg::SAMPLE_BITS-1:0] == speed_reg)))
    `ASSERT_NEXT(a_prev_holds, clk, rst_n, !stage_advance, prev_reg == $past(prev_reg))

endmodule

`default_nettype wire

@@ tb/median5_checker.sv @@
// Checker for the median-of-five filter: predicts every filter result from the
// accepted samples and compares it with what the output channel delivers.
// Depends on m5v_pkg for the window geometry and the sample and velocity types.

module median5_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  m5v_pkg::sample_t   adc_sample,
    input  logic               out_valid,
    input  logic               out_stall,
    input  m5v_pkg::sample_t   filtered_position,
    input  m5v_pkg::velocity_t velocity,
    input  m5v_pkg::sample_t   speed,
    output int                 fail_count,
    output int                 pending,
    output int                 results_checked
);

    typedef struct {
        m5v_pkg::sample_t   position;
        m5v_pkg::velocity_t velocity;
        m5v_pkg::sample_t   speed;
    } filter_result_t;

    // Results predicted but not yet delivered, oldest first.
    filter_result_t expected_results[$];

    // Predictor state: the sample ring, its write slot and the last median.
    m5v_pkg::sample_t sample_ring [m5v_pkg::WINDOW_SIZE];
    int unsigned      ring_slot;
    m5v_pkg::sample_t last_position;

    initial begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
    end

    always @(posedge clk or negedge rst_n) begin : predict_and_compare
        m5v_pkg::sample_t sorted [m5v_pkg::WINDOW_SIZE];
        m5v_pkg::sample_t key;
        int               j;
        filter_result_t   fresh;
        filter_result_t   oldest;

        if (!rst_n) begin
            for (int i = 0; i < m5v_pkg::WINDOW_SIZE; i++) begin
                sample_ring[i] = '0;
            end
            ring_slot     = 0;
            last_position = '0;
            expected_results.delete();
            pending       = 0;
        end
        else begin
            // Compare a delivered result with the oldest prediction.
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: position %0d velocity %0d speed %0d",
                           filtered_position, velocity, speed);
                    fail_count++;
                end
                else begin
                    oldest = expected_results.pop_front();
                    results_checked++;
                    if (filtered_position !== oldest.position) begin
                        $error("filtered_position: expected %0d, actual %0d",
                               oldest.position, filtered_position);
                        fail_count++;
                    end
                    if (velocity !== oldest.velocity) begin
                        $error("velocity: expected %0d, actual %0d",
                               oldest.velocity, velocity);
                        fail_count++;
                    end
                    if (speed !== oldest.speed) begin
                        $error("speed: expected %0d, actual %0d", oldest.speed, speed);
                        fail_count++;
                    end
                end
            end

            // An accepted sample overwrites the oldest ring entry.
            if (in_valid && !in_stall) begin
                sample_ring[ring_slot] = adc_sample;
                ring_slot = (ring_slot + 1) % m5v_pkg::WINDOW_SIZE;

                // Insertion sort of a copy; the middle rank is the median.
                for (int i = 0; i < m5v_pkg::WINDOW_SIZE; i++) begin
                    sorted[i] = sample_ring[i];
                end
                for (int i = 1; i < m5v_pkg::WINDOW_SIZE; i++) begin
                    key = sorted[i];
                    j = i - 1;
                    while (j >= 0 && sorted[j] > key) begin
                        sorted[j + 1] = sorted[j];
                        j--;
                    end
                    sorted[j + 1] = key;
                end
                fresh.position = sorted[m5v_pkg::MEDIAN_RANK];

                // Velocity is the signed step from the last median.
                fresh.velocity = m5v_pkg::velocity_t'({1'b0, fresh.position})
                               - m5v_pkg::velocity_t'({1'b0, last_position});
                if (fresh.position >= last_position) begin
                    fresh.speed = fresh.position - last_position;
                end
                else begin
                    fresh.speed = last_position - fresh.position;
                end
                last_position = fresh.position;
                expected_results.insert(expected_results.size(), fresh);
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the median filter testbench: clock, reset, sample stimulus, output
// stalls, watchdog and verdict. Depends on m5v_pkg, the filter RTL and median5_checker.

module testbench;

    localparam int SAMPLE_COUNT   = 1250;
    localparam int WATCHDOG_LIMIT = 2000;

    // Receiver behavior, redrawn at random whenever its current run ends.
    typedef enum int {
        RX_STREAM,
        RX_LIGHT,
        RX_HEAVY,
        RX_BURSTY
    } rx_mode_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    m5v_pkg::sample_t   adc_sample = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    m5v_pkg::sample_t   filtered_position;
    m5v_pkg::velocity_t velocity;
    m5v_pkg::sample_t   speed;

    int fail_count;
    int pending;
    int results_checked;

    rx_mode_t rx_mode   = RX_STREAM;
    int       rx_left   = 0;
    int       idle_cycles  = 0;
    int       samples_sent = 0;

    median5_filter_with_velocity DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .adc_sample        (adc_sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .filtered_position (filtered_position),
        .velocity          (velocity),
        .speed             (speed)
    );

    median5_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .adc_sample        (adc_sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .filtered_position (filtered_position),
        .velocity          (velocity),
        .speed             (speed),
        .fail_count        (fail_count),
        .pending           (pending),
        .results_checked   (results_checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Output stall pattern: no stall, light random, heavy random, or a periodic on/off pattern.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 300);
        end
        else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STREAM: out_stall <= 1'b0;
            RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
            default:   out_stall <= ((rx_left % 16) < 10);
        endcase
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                samples_sent <= samples_sent + 1;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("testbench failed");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Present one sample and hold it until the filter takes it.
    task automatic send_sample(input m5v_pkg::sample_t value);
        in_valid   <= 1'b1;
        adc_sample <= value;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    initial begin : stimulus
        m5v_pkg::sample_t directed [$];
        m5v_pkg::sample_t value;
        int               sent;
        int               burst;
        int               gap;
        int               walk;

        // Full-scale steps up and down, then bit patterns and edge values.
        directed = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                     12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                     12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'h001,
                     12'h800, 12'h7FF, 12'hFFE, 12'h000, 12'hFFF};
        sent = 0;
        walk = 2048;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bursts of requests with random gaps; some bursts are long and unbroken.
        while (sent < SAMPLE_COUNT) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < SAMPLE_COUNT; k++) begin
                if (sent < directed.size()) begin
                    value = directed[sent];
                end
                else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: value = m5v_pkg::sample_t'($urandom_range(0, 4095));
                        8: value = ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
                        9: value = ($urandom_range(0, 1) == 1) ?
                                   m5v_pkg::sample_t'($urandom_range(4080, 4095)) :
                                   m5v_pkg::sample_t'($urandom_range(0, 15));
                        default:
                        begin
                            // Noisy sensor walk with an occasional jump.
                            if ($urandom_range(0, 49) == 0) begin
                                walk = $urandom_range(0, 4095);
                            end
                            walk = walk + $urandom_range(0, 64) - 32;
                            if (walk < 0) begin
                                walk = 0;
                            end
                            if (walk > 4095) begin
                                walk = 4095;
                            end
                            value = m5v_pkg::sample_t'(walk);
                        end
                    endcase
                end
                send_sample(value);
                sent++;
            end
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (in_valid) begin
            in_valid <= 1'b0;
        end

        // Drain the outstanding results, then let the pipeline settle.
        do begin
            @(negedge clk);
        end while (pending != 0);
        repeat (8) @(negedge clk);

        $display("Run covered %0d samples and %0d checked filter results.",
                 samples_sent, results_checked);
        $display("Stimulus held full-scale steps, bit patterns, sensor walks and spikes.");
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end
        else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
